FILE: sv/abb_pkg.sv
// Package for the alpha blend blitter: sizes, codes, shared types.
// No dependencies; every other file but abb_ram takes names from here by scope.
`default_nettype none
package abb_pkg;

   localparam int MAX_DIM = 256;
   localparam int DIM_W   = $clog2(MAX_DIM);
   localparam int ADDR_W  = 2 * DIM_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int CFG_W   = 9;
   localparam int CNT_W   = DIM_W + 1;
   localparam int LEN_W   = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
   localparam int PXY_W   = LEN_W + 2;
   localparam int XY_W    = 10;
   localparam int PIX_W   = 32;
   localparam int CMD_W   = 3;
   localparam int IDX_W   = 2;
   localparam int SUM_W   = 16;

   localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0]       ALPHA_CLEAR  = 8'h00;
   localparam logic [SUM_W-1:0] DIV255_MUL   = 16'h8081;
   localparam int               DIV255_SHIFT = 23;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 3'd0,
      CMD_SET   = 3'd1,
      CMD_BLEND = 3'd2,
      CMD_CLEAR = 3'd3,
      CMD_BLIT  = 3'd4,
      CMD_TILE  = 3'd5,
      CMD_READ  = 3'd6,
      CMD_NONE  = 3'd7
   } cmd_type;

   typedef enum logic [IDX_W-1:0] {
      REG_DEST_WIDTH  = 2'd0,
      REG_DEST_HEIGHT = 2'd1,
      REG_SRC_WIDTH   = 2'd2,
      REG_SRC_HEIGHT  = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SETUP,
      ST_SRC_RD,
      ST_PIX,
      ST_MUL,
      ST_DIV,
      ST_ADV,
      ST_RD_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CFG_W-1:0] dest_width;
      logic [CFG_W-1:0] dest_height;
      logic [CFG_W-1:0] src_width;
      logic [CFG_W-1:0] src_height;
   } cfg_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic                    use_src;
      logic                    force_put;
      logic signed [XY_W-1:0]  dest_x;
      logic signed [XY_W-1:0]  dest_y;
      logic [CFG_W-1:0]        src_x;
      logic [CFG_W-1:0]        src_y;
      logic [CFG_W-1:0]        cell_w;
      logic [CFG_W-1:0]        cell_h;
      logic [PIX_W-1:0]        color;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic init_busy;
      logic pop;
   } bk_status_type;

endpackage
`default_nettype wire

FILE: sv/abb_if.sv
// Handshake channels for the blitter: command words in, result words out.
// Depends on abb_pkg for field widths.
`default_nettype none
interface abb_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [abb_pkg::CMD_W-1:0]              cmd;
   logic signed [abb_pkg::XY_W-1:0]        dest_x;
   logic signed [abb_pkg::XY_W-1:0]        dest_y;
   logic [abb_pkg::CFG_W-1:0]              src_x;
   logic [abb_pkg::CFG_W-1:0]              src_y;
   logic [abb_pkg::CFG_W-1:0]              cell_w;
   logic [abb_pkg::CFG_W-1:0]              cell_h;
   logic [abb_pkg::PIX_W-1:0]              color;

   modport source (output valid, cmd, dest_x, dest_y, src_x, src_y, cell_w, cell_h, color,
                   input ready);
   modport sink   (input valid, cmd, dest_x, dest_y, src_x, src_y, cell_w, cell_h, color,
                   output ready);
endinterface

interface abb_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [abb_pkg::PIX_W-1:0] read_pixel;
   logic                      done_res;

   modport source (output valid, read_pixel, done_res, input ready);
   modport sink   (input valid, read_pixel, done_res, output ready);
endinterface
`default_nettype wire

FILE: sv/abb_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module abb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

FILE: sv/abb_front.sv
// Front end: accepts command words, classifies them, holds them in a two entry queue.
// Depends on abb_pkg and abb_if.
`default_nettype none
module abb_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   abb_req_if.sink                    req,
   input  wire abb_pkg::bk_status_type status,
   output abb_pkg::head_type          head
);
   abb_pkg::item_type slot_ff [2];
   abb_pkg::item_type slot_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   abb_pkg::cmd_type  cmd;

   assign req.ready = (count_ff != 2'd2) && !status.init_busy;
   assign push      = req.valid && req.ready;
   assign cmd       = abb_pkg::cmd_type'(req.cmd);

   always_comb begin
      slot_in.cmd       = cmd;
      slot_in.use_src   = (cmd == abb_pkg::CMD_BLIT) || (cmd == abb_pkg::CMD_TILE);
      slot_in.force_put = (cmd == abb_pkg::CMD_SET) || (cmd == abb_pkg::CMD_CLEAR);
      slot_in.dest_x    = req.dest_x;
      slot_in.dest_y    = req.dest_y;
      slot_in.src_x     = req.src_x;
      slot_in.src_y     = req.src_y;
      slot_in.cell_w    = req.cell_w;
      slot_in.cell_h    = req.cell_h;
      slot_in.color     = req.color;
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = status.pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];
endmodule
`default_nettype wire

FILE: sv/abb_back.sv
// Back end: command sequencer, pixel walker, blend datapath, both pixel stores and
// the result register. Depends on abb_pkg, abb_if and abb_ram.
`default_nettype none
module abb_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire abb_pkg::cfg_type       cfg,
   input  wire abb_pkg::head_type      head,
   output abb_pkg::bk_status_type      status,
   abb_rsp_if.source                   rsp
);
   localparam int LW = abb_pkg::LEN_W;
   localparam int PW = abb_pkg::PXY_W;
   localparam int AW = abb_pkg::ADDR_W;
   localparam int DW = abb_pkg::DIM_W;

   function automatic logic [LW-1:0] clamp_dim(input logic [abb_pkg::CFG_W-1:0] v);
      logic [LW-1:0] lim;
      lim = LW'(abb_pkg::MAX_DIM);
      if (LW'(v) > lim) begin
         return lim;
      end
      return LW'(v);
   endfunction

   function automatic logic inside_dest(input logic signed [PW-1:0] x,
                                        input logic signed [PW-1:0] y,
                                        input logic [LW-1:0] w, input logic [LW-1:0] h);
      logic [PW-1:0] ux;
      logic [PW-1:0] uy;
      ux = x;
      uy = y;
      return (w != '0) && (h != '0) && !x[PW-1] && !y[PW-1] &&
             (ux < PW'(w)) && (uy < PW'(h));
   endfunction

   function automatic logic [AW-1:0] pix_addr(input logic [PW-1:0] x, input logic [PW-1:0] y);
      return {y[DW-1:0], x[DW-1:0]};
   endfunction

   abb_pkg::state_type       state_ff, state_in;
   abb_pkg::item_type        item_ff, item_in;
   logic [LW-1:0]            cols_ff, cols_in, rows_ff, rows_in;
   logic [LW-1:0]            c_ff, c_in, r_ff, r_in;
   logic signed [PW-1:0]     base_x_ff, base_x_in, base_y_ff, base_y_in;
   logic [abb_pkg::PIX_W-1:0] pcol_ff, pcol_in;
   logic [AW-1:0]            paddr_ff, paddr_in;
   logic [abb_pkg::SUM_W-1:0] sum_ff [3];
   logic [abb_pkg::SUM_W-1:0] sum_in [3];
   logic [abb_pkg::PIX_W-1:0] res_ff, res_in;
   logic [AW-1:0]            init_cnt_ff, init_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [abb_pkg::PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;

   logic [LW-1:0]            w, h, sw, sh, sx_l, sy_l, cw_l, ch_l;
   logic [LW-1:0]            cols_clip, rows_clip, c_nx, r_nx;
   logic                     src_ok, tile_go, rd_inside, load_ok;
   logic signed [PW-1:0]     dx_e, dy_e, px_x, px_y, bx_nx, by_nx;
   logic [LW-1:0]            sxc, syr;
   logic [abb_pkg::PIX_W-1:0] pix_color, blended, fb_rdata, src_rdata;
   logic [7:0]               alpha, inv;
   logic                     px_in, do_put, need_blend, rsp_free;
   abb_pkg::state_type       px_state;
   logic [2*abb_pkg::SUM_W-1:0] prod [3];

   logic                     fb_we, src_we;
   logic [AW-1:0]            fb_waddr, fb_raddr, src_waddr, src_raddr;
   logic [abb_pkg::PIX_W-1:0] fb_wdata, src_wdata;

   abb_ram #(.WIDTH(abb_pkg::PIX_W), .DEPTH(abb_pkg::DEPTH)) u_frame (
      .clock(clock), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
      .raddr(fb_raddr), .rdata(fb_rdata)
   );

   abb_ram #(.WIDTH(abb_pkg::PIX_W), .DEPTH(abb_pkg::DEPTH)) u_source (
      .clock(clock), .we(src_we), .waddr(src_waddr), .wdata(src_wdata),
      .raddr(src_raddr), .rdata(src_rdata)
   );

   always_comb begin
      w         = clamp_dim(cfg.dest_width);
      h         = clamp_dim(cfg.dest_height);
      sw        = clamp_dim(cfg.src_width);
      sh        = clamp_dim(cfg.src_height);
      sx_l      = LW'(item_ff.src_x);
      sy_l      = LW'(item_ff.src_y);
      cw_l      = LW'(item_ff.cell_w);
      ch_l      = LW'(item_ff.cell_h);
      src_ok    = (sx_l < sw) && (sy_l < sh);
      cols_clip = (cw_l < (sw - sx_l)) ? cw_l : (sw - sx_l);
      rows_clip = (ch_l < (sh - sy_l)) ? ch_l : (sh - sy_l);
      tile_go   = src_ok && (cw_l != '0) && (ch_l != '0) && (w != '0) && (h != '0);
      dx_e      = PW'(item_ff.dest_x);
      dy_e      = PW'(item_ff.dest_y);
      rd_inside = inside_dest(dx_e, dy_e, w, h);
      load_ok   = src_ok;
      px_x      = base_x_ff + $signed(PW'(c_ff));
      px_y      = base_y_ff + $signed(PW'(r_ff));
      sxc       = sx_l + c_ff;
      syr       = sy_l + r_ff;
      pix_color = item_ff.use_src ? src_rdata : item_ff.color;
      alpha     = pix_color[31:24];
      inv       = abb_pkg::ALPHA_OPAQUE - pcol_ff[31:24];
      px_in     = inside_dest(px_x, px_y, w, h);
      do_put    = px_in && (item_ff.force_put || (alpha == abb_pkg::ALPHA_OPAQUE));
      need_blend = px_in && !item_ff.force_put && (alpha != abb_pkg::ALPHA_OPAQUE) &&
                   (alpha != abb_pkg::ALPHA_CLEAR);
      c_nx      = c_ff + LW'(1);
      r_nx      = r_ff + LW'(1);
      bx_nx     = base_x_ff + $signed(PW'(item_ff.cell_w));
      by_nx     = base_y_ff + $signed(PW'(item_ff.cell_h));
      px_state  = item_ff.use_src ? abb_pkg::ST_SRC_RD : abb_pkg::ST_PIX;
      rsp_free  = !rsp_valid_ff || rsp.ready;
      for (int i = 0; i < 3; i++) begin
         prod[i] = 32'(sum_ff[i]) * 32'(abb_pkg::DIV255_MUL);
      end
      blended = {abb_pkg::ALPHA_OPAQUE,
                 prod[2][abb_pkg::DIV255_SHIFT+7:abb_pkg::DIV255_SHIFT],
                 prod[1][abb_pkg::DIV255_SHIFT+7:abb_pkg::DIV255_SHIFT],
                 prod[0][abb_pkg::DIV255_SHIFT+7:abb_pkg::DIV255_SHIFT]};
   end

   // next state and datapath registers
   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      cols_in     = cols_ff;
      rows_in     = rows_ff;
      c_in        = c_ff;
      r_in        = r_ff;
      base_x_in   = base_x_ff;
      base_y_in   = base_y_ff;
      pcol_in     = pcol_ff;
      paddr_in    = paddr_ff;
      res_in      = res_ff;
      init_cnt_in = init_cnt_ff;
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = sum_ff[i];
      end
      case (state_ff)
         abb_pkg::ST_INIT: begin
            init_cnt_in = init_cnt_ff + AW'(1);
            if (init_cnt_ff == '1) begin
               state_in = abb_pkg::ST_IDLE;
            end
         end
         abb_pkg::ST_IDLE: begin
            if (head.valid) begin
               item_in  = head.item;
               state_in = abb_pkg::ST_SETUP;
            end
         end
         abb_pkg::ST_SETUP: begin
            res_in    = '0;
            c_in      = '0;
            r_in      = '0;
            base_x_in = dx_e;
            base_y_in = dy_e;
            cols_in   = LW'(1);
            rows_in   = LW'(1);
            case (item_ff.cmd)
               abb_pkg::CMD_SET, abb_pkg::CMD_BLEND: begin
                  state_in = abb_pkg::ST_PIX;
               end
               abb_pkg::CMD_CLEAR: begin
                  base_x_in = '0;
                  base_y_in = '0;
                  cols_in   = w;
                  rows_in   = h;
                  state_in  = ((w == '0) || (h == '0)) ? abb_pkg::ST_RESP : abb_pkg::ST_PIX;
               end
               abb_pkg::CMD_BLIT: begin
                  cols_in  = cols_clip;
                  rows_in  = rows_clip;
                  state_in = (src_ok && (cols_clip != '0) && (rows_clip != '0)) ?
                             abb_pkg::ST_SRC_RD : abb_pkg::ST_RESP;
               end
               abb_pkg::CMD_TILE: begin
                  base_x_in = '0;
                  base_y_in = '0;
                  cols_in   = cols_clip;
                  rows_in   = rows_clip;
                  state_in  = tile_go ? abb_pkg::ST_SRC_RD : abb_pkg::ST_RESP;
               end
               abb_pkg::CMD_READ: begin
                  state_in = rd_inside ? abb_pkg::ST_RD_WAIT : abb_pkg::ST_RESP;
               end
               default: begin
                  state_in = abb_pkg::ST_RESP;
               end
            endcase
         end
         abb_pkg::ST_SRC_RD: begin
            state_in = abb_pkg::ST_PIX;
         end
         abb_pkg::ST_PIX: begin
            pcol_in  = pix_color;
            paddr_in = pix_addr(px_x, px_y);
            state_in = need_blend ? abb_pkg::ST_MUL : abb_pkg::ST_ADV;
         end
         abb_pkg::ST_MUL: begin
            for (int i = 0; i < 3; i++) begin
               sum_in[i] = abb_pkg::SUM_W'(16'(pcol_ff[8*i +: 8]) * 16'(pcol_ff[31:24])) +
                           abb_pkg::SUM_W'(16'(fb_rdata[8*i +: 8]) * 16'(inv));
            end
            state_in = abb_pkg::ST_DIV;
         end
         abb_pkg::ST_DIV: begin
            state_in = abb_pkg::ST_ADV;
         end
         abb_pkg::ST_ADV: begin
            if (c_nx < cols_ff) begin
               c_in     = c_nx;
               state_in = px_state;
            end else begin
               c_in = '0;
               if (r_nx < rows_ff) begin
                  r_in     = r_nx;
                  state_in = px_state;
               end else begin
                  r_in     = '0;
                  state_in = abb_pkg::ST_RESP;
                  if (item_ff.cmd == abb_pkg::CMD_TILE) begin
                     if (bx_nx < $signed(PW'(w))) begin
                        base_x_in = bx_nx;
                        state_in  = px_state;
                     end else if (by_nx < $signed(PW'(h))) begin
                        base_x_in = '0;
                        base_y_in = by_nx;
                        state_in  = px_state;
                     end
                  end
               end
            end
         end
         abb_pkg::ST_RD_WAIT: begin
            res_in   = fb_rdata;
            state_in = abb_pkg::ST_RESP;
         end
         abb_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = abb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abb_pkg::ST_IDLE;
         end
      endcase
   end

   // store ports, queue pop and result register
   always_comb begin
      fb_we        = 1'b0;
      fb_waddr     = paddr_ff;
      fb_wdata     = blended;
      fb_raddr     = (state_ff == abb_pkg::ST_SETUP) ? pix_addr(dx_e, dy_e) : pix_addr(px_x, px_y);
      src_we       = 1'b0;
      src_waddr    = {sy_l[DW-1:0], sx_l[DW-1:0]};
      src_wdata    = {item_ff.color[7:0], item_ff.color[15:8],
                      item_ff.color[23:16], item_ff.color[31:24]};
      src_raddr    = {syr[DW-1:0], sxc[DW-1:0]};
      status.pop       = 1'b0;
      status.init_busy = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pixel_in = rsp_pixel_ff;
      case (state_ff)
         abb_pkg::ST_INIT: begin
            status.init_busy = 1'b1;
            fb_we    = 1'b1;
            fb_waddr = init_cnt_ff;
            fb_wdata = '0;
         end
         abb_pkg::ST_IDLE: begin
            status.pop = head.valid;
         end
         abb_pkg::ST_SETUP: begin
            src_we = (item_ff.cmd == abb_pkg::CMD_LOAD) && load_ok;
         end
         abb_pkg::ST_PIX: begin
            fb_we    = do_put;
            fb_waddr = pix_addr(px_x, px_y);
            fb_wdata = pix_color;
         end
         abb_pkg::ST_DIV: begin
            fb_we = 1'b1;
         end
         abb_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = res_ff;
            end
         end
         default: begin
            fb_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abb_pkg::ST_INIT;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      cols_ff      <= cols_in;
      rows_ff      <= rows_in;
      c_ff         <= c_in;
      r_ff         <= r_in;
      base_x_ff    <= base_x_in;
      base_y_ff    <= base_y_in;
      pcol_ff      <= pcol_in;
      paddr_ff     <= paddr_in;
      res_ff       <= res_in;
      rsp_pixel_ff <= rsp_pixel_in;
      for (int i = 0; i < 3; i++) begin
         sum_ff[i] <= sum_in[i];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_pixel = rsp_pixel_ff;
   assign rsp.done_res   = 1'b1;
endmodule
`default_nettype wire

FILE: sv/alpha_blend_blitter_unit.sv
// Alpha blend blitter top level. One command at a time in the back end; a two word queue
// takes commands meanwhile. Reset is synchronous: it clears the control state and then
// zeroes all 65536 framebuffer entries, one entry a cycle, with req_bus.ready low.
// Depends on abb_pkg, abb_if, abb_front and abb_back.
`default_nettype none
module alpha_blend_blitter_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   abb_req_if.sink                         req_bus,
   abb_rsp_if.source                       rsp_bus,
   input  wire logic                       csr_we,
   input  wire logic [abb_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [abb_pkg::CFG_W-1:0]  csr_wdata
);
   abb_pkg::cfg_type       cfg_ff, cfg_in;
   abb_pkg::head_type      head;
   abb_pkg::bk_status_type status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (abb_pkg::reg_index_type'(csr_index))
            abb_pkg::REG_DEST_WIDTH:  cfg_in.dest_width  = csr_wdata;
            abb_pkg::REG_DEST_HEIGHT: cfg_in.dest_height = csr_wdata;
            abb_pkg::REG_SRC_WIDTH:   cfg_in.src_width   = csr_wdata;
            abb_pkg::REG_SRC_HEIGHT:  cfg_in.src_height  = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   abb_front u_front (
      .clock(clock), .reset(reset), .req(req_bus), .status(status), .head(head)
   );

   abb_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .head(head), .status(status), .rsp(rsp_bus)
   );
endmodule
`default_nettype wire

FILE: sv/abb_checker.sv
// Port level checks for the blitter top level, attached by bind.
// Depends on alpha_blend_blitter_unit.
`default_nettype none
module abb_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [abb_pkg::PIX_W-1:0] rsp_pixel,
   input wire logic                      rsp_done
);
   logic [2:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel))
      else $error("result word dropped or changed while stalled");

   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_done)
      else $error("result word without done flag");

   a_init_block: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("command taken before framebuffer clear");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("result word with no command outstanding");
endmodule

bind alpha_blend_blitter_unit abb_checker u_abb_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_bus.valid), .req_ready(req_bus.ready),
   .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready),
   .rsp_pixel(rsp_bus.read_pixel), .rsp_done(rsp_bus.done_res)
);
`default_nettype wire

FILE: tb/alpha_blend_blitter_unit_tb.sv
// Self-checking bench for alpha_blend_blitter_unit: directed and random command words with an
// in-bench pixel predictor. Depends on abb_pkg, abb_if and the unit itself.
`timescale 1ns / 1ps
`default_nettype none
module alpha_blend_blitter_unit_tb;

   typedef struct {
      abb_pkg::cmd_type  cmd;
      logic signed [9:0] dx;
      logic signed [9:0] dy;
      logic [8:0]        sx;
      logic [8:0]        sy;
      logic [8:0]        cw;
      logic [8:0]        ch;
      logic [31:0]       color;
   } blit_word_type;

   class pixel_scoreboard;
      bit [31:0] frame_mem [0:65535];
      bit [31:0] src_mem [0:65535];
      int        dst_w, dst_h, src_w, src_h;
      bit [31:0] pending_pixels [$];
      int        mismatches;

      function int lim(int v);
         return (v > abb_pkg::MAX_DIM) ? abb_pkg::MAX_DIM : v;
      endfunction

      function void set_reg(abb_pkg::reg_index_type idx, int val);
         case (idx)
            abb_pkg::REG_DEST_WIDTH:  dst_w = val;
            abb_pkg::REG_DEST_HEIGHT: dst_h = val;
            abb_pkg::REG_SRC_WIDTH:   src_w = val;
            default:                  src_h = val;
         endcase
      endfunction

      function bit in_frame(int x, int y);
         if (lim(dst_w) == 0 || lim(dst_h) == 0 || x < 0 || y < 0) return 0;
         return x < lim(dst_w) && y < lim(dst_h);
      endfunction

      function void mix_pixel(int x, int y, bit [31:0] c);
         bit [31:0] d;
         int        a, inv, r, g, b;
         a = c[31:24];
         if (a == 0) return;
         if (!in_frame(x, y)) return;
         if (a == 255) begin
            frame_mem[y * abb_pkg::MAX_DIM + x] = c;
            return;
         end
         d   = frame_mem[y * abb_pkg::MAX_DIM + x];
         inv = 255 - a;
         r = (c[23:16] * a + d[23:16] * inv) / 255;
         g = (c[15:8] * a + d[15:8] * inv) / 255;
         b = (c[7:0] * a + d[7:0] * inv) / 255;
         frame_mem[y * abb_pkg::MAX_DIM + x] = {8'hFF, r[7:0], g[7:0], b[7:0]};
      endfunction

      function void copy_cell(int dx, int dy, int sx, int sy, int cw, int ch);
         int sw, sh, rows, cols;
         sw = lim(src_w);
         sh = lim(src_h);
         if (sx >= sw || sy >= sh) return;
         rows = (ch < sh - sy) ? ch : sh - sy;
         cols = (cw < sw - sx) ? cw : sw - sx;
         for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
               mix_pixel(dx + c, dy + r, src_mem[(sy + r) * abb_pkg::MAX_DIM + sx + c]);
      endfunction

      function void note_word(blit_word_type w);
         int        dx, dy, fw, fh;
         bit [31:0] pix;
         dx  = int'(w.dx);
         dy  = int'(w.dy);
         fw  = lim(dst_w);
         fh  = lim(dst_h);
         pix = 0;
         case (w.cmd)
            abb_pkg::CMD_LOAD:
               if (w.sx < lim(src_w) && w.sy < lim(src_h))
                  src_mem[w.sy * abb_pkg::MAX_DIM + w.sx] =
                     {w.color[7:0], w.color[15:8], w.color[23:16], w.color[31:24]};
            abb_pkg::CMD_SET:
               if (in_frame(dx, dy)) frame_mem[dy * abb_pkg::MAX_DIM + dx] = w.color;
            abb_pkg::CMD_BLEND: mix_pixel(dx, dy, w.color);
            abb_pkg::CMD_CLEAR:
               for (int y = 0; y < fh; y++)
                  for (int x = 0; x < fw; x++) frame_mem[y * abb_pkg::MAX_DIM + x] = w.color;
            abb_pkg::CMD_BLIT:  copy_cell(dx, dy, w.sx, w.sy, w.cw, w.ch);
            abb_pkg::CMD_TILE:
               if (w.cw != 0 && w.ch != 0)
                  for (int y = 0; y < fh; y += w.ch)
                     for (int x = 0; x < fw; x += w.cw)
                        copy_cell(x, y, w.sx, w.sy, w.cw, w.ch);
            abb_pkg::CMD_READ:
               if (in_frame(dx, dy)) pix = frame_mem[dy * abb_pkg::MAX_DIM + dx];
            default: ;
         endcase
         pending_pixels.push_back(pix);
      endfunction

      function void check_word(bit [31:0] pix, bit done);
         bit [31:0] want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word pixel=%h", pix);
            return;
         end
         want = pending_pixels.pop_front();
         if (pix !== want || done !== 1'b1) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: pixel exp %h got %h, done exp 1 got %b", want, pix, done);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [abb_pkg::IDX_W-1:0] csr_index;
   logic [abb_pkg::CFG_W-1:0] csr_wdata;
   bit   calm;
   pixel_scoreboard sb;

   abb_req_if req_bus ();
   abb_rsp_if rsp_bus ();

   alpha_blend_blitter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= !reset && (calm || $urandom_range(99) >= 26);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_word(rsp_bus.read_pixel, rsp_bus.done_res);
   end

   initial begin
      #250ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic write_reg(abb_pkg::reg_index_type idx, int val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[8:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic send_word(blit_word_type w);
      while (!calm && $urandom_range(99) < 26) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.cmd    <= w.cmd;
      req_bus.dest_x <= w.dx;
      req_bus.dest_y <= w.dy;
      req_bus.src_x  <= w.sx;
      req_bus.src_y  <= w.sy;
      req_bus.cell_w <= w.cw;
      req_bus.cell_h <= w.ch;
      req_bus.color  <= w.color;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_word(w);
   endtask

   task automatic send_cmd(abb_pkg::cmd_type c, int dx, int dy, int sx, int sy, int cw,
                           int ch, logic [31:0] color);
      blit_word_type w;
      w.cmd = c;
      w.dx = dx[9:0];
      w.dy = dy[9:0];
      w.sx = sx[8:0];
      w.sy = sy[8:0];
      w.cw = cw[8:0];
      w.ch = ch[8:0];
      w.color = color;
      send_word(w);
   endtask

   // hold off until the block is idle again
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic fill_source();
      for (int y = 0; y < sb.lim(sb.src_h); y++)
         for (int x = 0; x < sb.lim(sb.src_w); x++)
            send_cmd(abb_pkg::CMD_LOAD, 0, 0, x, y, 0, 0, $urandom);
   endtask

   function automatic int pick_xy(int span);
      if ($urandom_range(9) == 0) return $urandom_range(1023) - 512;
      return $urandom_range(span + 5) - 3;
   endfunction

   function automatic logic [31:0] pick_color();
      logic [31:0] c;
      c = $urandom;
      case ($urandom_range(3))
         0: c[31:24] = abb_pkg::ALPHA_CLEAR;
         1: c[31:24] = abb_pkg::ALPHA_OPAQUE;
         default: ;
      endcase
      return c;
   endfunction

   task automatic random_word();
      int k, sw, sh, fw, fh, cw, ch;
      sw = sb.lim(sb.src_w);
      sh = sb.lim(sb.src_h);
      fw = sb.lim(sb.dst_w);
      fh = sb.lim(sb.dst_h);
      cw = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(sw + 2);
      ch = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(sh + 2);
      k = $urandom_range(99);
      if (k < 10)
         send_cmd(abb_pkg::CMD_LOAD, $urandom, $urandom,
                  ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(sw + 1),
                  ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(sh + 1),
                  $urandom, $urandom, $urandom);
      else if (k < 25)
         send_cmd(abb_pkg::CMD_SET, pick_xy(fw), pick_xy(fh), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      else if (k < 48)
         send_cmd(abb_pkg::CMD_BLEND, pick_xy(fw), pick_xy(fh), $urandom, $urandom, $urandom,
                  $urandom, pick_color());
      else if (k < 52)
         send_cmd(abb_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, pick_color());
      else if (k < 72)
         send_cmd(abb_pkg::CMD_BLIT, pick_xy(fw), pick_xy(fh),
                  ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(sw),
                  ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(sh),
                  cw, ch, $urandom);
      else if (k < 77)
         send_cmd(abb_pkg::CMD_TILE, $urandom, $urandom, $urandom_range(sw),
                  $urandom_range(sh), $urandom_range(sw + 1), $urandom_range(sh + 1),
                  $urandom);
      else if (k < 98)
         send_cmd(abb_pkg::CMD_READ, pick_xy(fw), pick_xy(fh), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      else
         send_cmd(abb_pkg::CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
   endtask

   initial begin
      int k;
      sb = new;
      clock = 1'b0;
      reset = 1'b1;
      calm = 1'b0;
      csr_we = 1'b0;
      csr_index = abb_pkg::REG_DEST_WIDTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.cmd = abb_pkg::CMD_NONE;
      req_bus.dest_x = '0;
      req_bus.dest_y = '0;
      req_bus.src_x = '0;
      req_bus.src_y = '0;
      req_bus.cell_w = '0;
      req_bus.cell_h = '0;
      req_bus.color = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_reg(abb_pkg::REG_DEST_WIDTH, 511);
      write_reg(abb_pkg::REG_DEST_HEIGHT, 256);
      write_reg(abb_pkg::REG_SRC_WIDTH, 3);
      write_reg(abb_pkg::REG_SRC_HEIGHT, 2);
      send_cmd(abb_pkg::CMD_READ, 255, 255, 0, 0, 0, 0, 0);
      fill_source();
      send_cmd(abb_pkg::CMD_LOAD, 0, 0, 3, 0, 0, 0, 32'hFFFF_FFFF);
      send_cmd(abb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 32'h80FF_00FF);
      send_cmd(abb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(abb_pkg::CMD_READ, 255, 255, 0, 0, 0, 0, 0);
      send_cmd(abb_pkg::CMD_READ, 256, 0, 0, 0, 0, 0, 0);
      send_cmd(abb_pkg::CMD_READ, -1, 0, 0, 0, 0, 0, 0);
      send_cmd(abb_pkg::CMD_READ, -512, 511, 0, 0, 0, 0, 0);
      send_cmd(abb_pkg::CMD_SET, 255, 255, 0, 0, 0, 0, 32'h0012_3456);
      send_cmd(abb_pkg::CMD_SET, 256, 5, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_cmd(abb_pkg::CMD_BLEND, 255, 255, 0, 0, 0, 0, 32'h00AA_BBCC);
      send_cmd(abb_pkg::CMD_BLEND, 255, 255, 0, 0, 0, 0, 32'h7FFF_FFFF);
      send_cmd(abb_pkg::CMD_READ, 255, 255, 0, 0, 0, 0, 0);
      send_cmd(abb_pkg::CMD_BLEND, 255, 255, 0, 0, 0, 0, 32'hFF01_0203);
      send_cmd(abb_pkg::CMD_BLEND, 0, 0, 0, 0, 0, 0, 32'h01FF_FFFF);
      send_cmd(abb_pkg::CMD_BLIT, -2, -2, 1, 1, 511, 511, 0);
      send_cmd(abb_pkg::CMD_BLIT, 254, 255, 0, 0, 511, 511, 0);
      send_cmd(abb_pkg::CMD_BLIT, 10, 10, 3, 0, 4, 4, 0);
      send_cmd(abb_pkg::CMD_TILE, 0, 0, 0, 0, 0, 5, 0);
      send_cmd(abb_pkg::CMD_NONE, 1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF);
      send_cmd(abb_pkg::CMD_READ, -1, -1, 0, 0, 0, 0, 0);
      send_cmd(abb_pkg::CMD_READ, 254, 255, 0, 0, 0, 0, 0);
      drain();
      write_reg(abb_pkg::REG_DEST_WIDTH, 0);
      send_cmd(abb_pkg::CMD_SET, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_cmd(abb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 32'h1111_1111);
      send_cmd(abb_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         calm = (phase == 5);
         k = $urandom_range(5);
         if (k == 0) begin
            write_reg(abb_pkg::REG_DEST_WIDTH, 0);
            write_reg(abb_pkg::REG_DEST_HEIGHT, $urandom_range(1, 20));
         end else if (k == 1) begin
            write_reg(abb_pkg::REG_DEST_WIDTH, $urandom_range(256, 511));
            write_reg(abb_pkg::REG_DEST_HEIGHT, $urandom_range(1, 2));
         end else if (k == 2) begin
            write_reg(abb_pkg::REG_DEST_WIDTH, $urandom_range(1, 2));
            write_reg(abb_pkg::REG_DEST_HEIGHT, $urandom_range(256, 511));
         end else begin
            write_reg(abb_pkg::REG_DEST_WIDTH, $urandom_range(1, 24));
            write_reg(abb_pkg::REG_DEST_HEIGHT, $urandom_range(0, 24));
         end
         k = $urandom_range(11);
         if (k == 0) begin
            write_reg(abb_pkg::REG_SRC_WIDTH, $urandom_range(256, 511));
            write_reg(abb_pkg::REG_SRC_HEIGHT, 1);
         end else if (k == 1) begin
            write_reg(abb_pkg::REG_SRC_WIDTH, 0);
            write_reg(abb_pkg::REG_SRC_HEIGHT, $urandom_range(511));
         end else begin
            write_reg(abb_pkg::REG_SRC_WIDTH, $urandom_range(1, 6));
            write_reg(abb_pkg::REG_SRC_HEIGHT, $urandom_range(1, 6));
         end
         fill_source();
         for (int n = 0; n < 30; n++) random_word();
         drain();
      end
      calm = 1'b0;

      if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
